>>> design/wpq_pkg.sv
// ----------------------------------------------------------------------------
// wpq_pkg: shared types and constants of the weighted priority task queue
// Item structs, operation and status codes, class codes and the slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package wpq_pkg;

    // defaults for the top level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_BUSY_DEF    = 63;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPTING   = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  LIMIT_RESET     = 5'd16;

    // field widths fixed by the interface
    localparam int HANDLE_W = 32;
    localparam int SEQ_W    = 32;
    localparam int QCOUNT_W = 5;
    localparam int BCOUNT_W = 6;

    // operation codes
    localparam logic [1:0] KIND_PUSH     = 2'd0;
    localparam logic [1:0] KIND_POP      = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_FLUSH    = 2'd3;

    // status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_REJ_FULL  = 3'd1;
    localparam logic [2:0] STATUS_HELD_FULL = 3'd2;
    localparam logic [2:0] STATUS_CLOSED    = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    // priority classes
    localparam int         CLASS_COUNT = 3;
    localparam logic [1:0] CLS_HIGH    = 2'd0;
    localparam logic [1:0] CLS_NORMAL  = 2'd1;
    localparam logic [1:0] CLS_LOW     = 2'd2;

    localparam int         SLOT_COUNT = 7;
    localparam logic [2:0] SLOT_LAST  = 3'd6;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          task_priority;
        logic [HANDLE_W-1:0] task_handle;
        logic                wait_if_full;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] granted_handle;
        logic [1:0]          granted_priority;
        logic [SEQ_W-1:0]    granted_sequence;
        logic [QCOUNT_W-1:0] queued_count;
        logic [BCOUNT_W-1:0] busy_count;
        logic                idle;
        logic [QCOUNT_W-1:0] dropped_count;
    } out_item_t;

    // weighted round robin table: four high, two normal, one low
    function automatic logic [1:0] slot_class(input logic [2:0] slot);
        logic [1:0] cls;
        case (slot) inside
            3'd0, 3'd1, 3'd2, 3'd3: cls = CLS_HIGH;
            3'd4, 3'd5:             cls = CLS_NORMAL;
            default:                cls = CLS_LOW;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> design/weighted_priority_task_queue_core.sv
// ----------------------------------------------------------------------------
// weighted_priority_task_queue_core: three-class task queue with weighted pops
// Per-class fifos in one shared ram, weighted round robin pop, busy tracking.
// ----------------------------------------------------------------------------
// The block works on one item at a time. In the accept cycle the class heads,
// tails, fills, slot pointer, sequence and busy counters are updated and the
// class ram is written for an accepted push or read at the head of the chosen
// class for a pop that finds an item; in the done state the result is built
// from the registered ram read data and moves to the output register once that
// register is free. The output register lets the next item be accepted while
// a result still waits there. The ram needs no clearing after reset.
`default_nettype none

module weighted_priority_task_queue_core
    import wpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_BUSY    = MAX_BUSY_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_item,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = FILL_W + 2;
    localparam int LIM_W     = (FILL_W > CFG_DATA_W) ? FILL_W : CFG_DATA_W;
    localparam int BUSY_W    = $clog2(MAX_BUSY + 1);
    localparam int RAM_DEPTH = CLASS_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int WORD_W    = SEQ_W + HANDLE_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DONE = 1'b1;

    logic                  state_reg, state_next;
    logic [CFG_DATA_W-1:0] limit_reg;
    logic                  accepting_reg;

    logic [FILL_W-1:0] fill_reg [CLASS_COUNT];
    logic [FILL_W-1:0] fill_next [CLASS_COUNT];
    logic [PTR_W-1:0]  head_reg [CLASS_COUNT];
    logic [PTR_W-1:0]  head_next [CLASS_COUNT];
    logic [PTR_W-1:0]  tail_reg [CLASS_COUNT];
    logic [PTR_W-1:0]  tail_next [CLASS_COUNT];
    logic [2:0]        slot_reg, slot_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [BUSY_W-1:0] busy_reg, busy_next;

    out_item_t res_reg, res_next;
    logic      hit_reg, hit_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic              out_load;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    wpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_class_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    function automatic logic [ADDR_W-1:0] class_addr(input logic [1:0] cls,
                                                     input logic [PTR_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        case (cls)
            CLS_HIGH:   base = '0;
            CLS_NORMAL: base = ADDR_W'(QUEUE_DEPTH);
            default:    base = ADDR_W'(2 * QUEUE_DEPTH);
        endcase
        return base + ADDR_W'(idx);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        logic [1:0]          push_cls;
        logic [1:0]          pop_cls;
        logic [SUM_W-1:0]    total;
        logic [SUM_W-1:0]    total_after;
        logic [LIM_W-1:0]    lim_ext;
        logic [FILL_W-1:0]   eff_limit;
        logic [CLASS_COUNT-1:0] nonempty;
        logic                found;
        logic [2:0]          sel_slot;
        logic [3:0]          slot_sum;
        logic [2:0]          slot;
        logic [PTR_W-1:0]    push_tail;
        logic [PTR_W-1:0]    pop_head;

        push_cls  = (in_item.task_priority > CLS_LOW) ? CLS_LOW : in_item.task_priority;
        total     = SUM_W'(fill_reg[0]) + SUM_W'(fill_reg[1]) + SUM_W'(fill_reg[2]);
        lim_ext   = LIM_W'(limit_reg);
        // zero acts as one, anything above the depth acts as the depth
        if (lim_ext == '0)
        begin
            eff_limit = FILL_W'(1);
        end
        else if (lim_ext > LIM_W'(QUEUE_DEPTH))
        begin
            eff_limit = FILL_W'(QUEUE_DEPTH);
        end
        else
        begin
            eff_limit = FILL_W'(lim_ext);
        end

        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            nonempty[c] = (fill_reg[c] != '0);
        end

        // walk the seven-slot table from the rotating pointer
        found    = 1'b0;
        sel_slot = '0;
        for (int off = 0; off < SLOT_COUNT; off++)
        begin
            slot_sum = {1'b0, slot_reg} + 4'(off);
            slot     = (slot_sum >= 4'(SLOT_COUNT)) ? 3'(slot_sum - 4'(SLOT_COUNT))
                                                    : slot_sum[2:0];
            if (!found && nonempty[slot_class(slot)])
            begin
                found    = 1'b1;
                sel_slot = slot;
            end
        end
        pop_cls = slot_class(sel_slot);

        push_tail = '0;
        pop_head  = '0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (2'(c) == push_cls)
            begin
                push_tail = tail_reg[c];
            end
            if (2'(c) == pop_cls)
            begin
                pop_head = head_reg[c];
            end
        end

        fill_next   = fill_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        slot_next   = slot_reg;
        seq_next    = seq_reg;
        busy_next   = busy_reg;
        res_next    = res_reg;
        hit_next    = hit_reg;
        ram_we      = 1'b0;
        ram_wr_addr = class_addr(push_cls, push_tail);
        ram_wr_data = {seq_reg, in_item.task_handle};
        ram_re      = 1'b0;
        ram_rd_addr = class_addr(pop_cls, pop_head);

        if (accept)
        begin
            res_next = '0;
            hit_next = 1'b0;
            case (in_item.kind)
                KIND_PUSH:
                begin
                    if (!accepting_reg)
                    begin
                        res_next.status = STATUS_CLOSED;
                    end
                    else if (total >= SUM_W'(eff_limit))
                    begin
                        res_next.status = in_item.wait_if_full ? STATUS_HELD_FULL
                                                               : STATUS_REJ_FULL;
                    end
                    else
                    begin
                        ram_we                    = 1'b1;
                        res_next.granted_sequence = seq_reg;
                        seq_next                  = seq_reg + 1'b1;
                        for (int c = 0; c < CLASS_COUNT; c++)
                        begin
                            if (2'(c) == push_cls)
                            begin
                                tail_next[c] = ptr_inc(tail_reg[c]);
                                fill_next[c] = fill_reg[c] + 1'b1;
                            end
                        end
                    end
                end
                KIND_POP:
                begin
                    if (found)
                    begin
                        ram_re                    = 1'b1;
                        hit_next                  = 1'b1;
                        res_next.granted_priority = pop_cls;
                        slot_next = (sel_slot == SLOT_LAST) ? '0 : sel_slot + 1'b1;
                        if (busy_reg != BUSY_W'(MAX_BUSY))
                        begin
                            busy_next = busy_reg + 1'b1;
                        end
                        for (int c = 0; c < CLASS_COUNT; c++)
                        begin
                            if (2'(c) == pop_cls)
                            begin
                                head_next[c] = ptr_inc(head_reg[c]);
                                fill_next[c] = fill_reg[c] - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        res_next.status = STATUS_EMPTY;
                    end
                end
                KIND_COMPLETE:
                begin
                    if (busy_reg != '0)
                    begin
                        busy_next = busy_reg - 1'b1;
                    end
                end
                default:
                begin
                    res_next.dropped_count = QCOUNT_W'(total);
                    for (int c = 0; c < CLASS_COUNT; c++)
                    begin
                        head_next[c] = '0;
                        tail_next[c] = '0;
                        fill_next[c] = '0;
                    end
                end
            endcase
            total_after = SUM_W'(fill_next[0]) + SUM_W'(fill_next[1])
                        + SUM_W'(fill_next[2]);
            res_next.queued_count = QCOUNT_W'(total_after);
            res_next.busy_count   = BCOUNT_W'(busy_next);
            res_next.idle         = (total_after == '0) && (busy_next == '0);
        end
        else
        begin
            total_after = total;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
            // pop data arrives from the registered ram read
            if (hit_reg)
            begin
                out_next.granted_handle   = ram_rd_data[HANDLE_W-1:0];
                out_next.granted_sequence = ram_rd_data[WORD_W-1:HANDLE_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            accepting_reg <= 1'b1;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                fill_reg[c] <= '0;
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
            end
            slot_reg      <= '0;
            seq_reg       <= SEQ_W'(1);
            busy_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            slot_reg      <= slot_next;
            seq_reg       <= seq_next;
            busy_reg      <= busy_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_QUEUE_LIMIT: limit_reg     <= cfg_data;
                    CFG_ACCEPTING:   accepting_reg <= cfg_data[0];
                    default:         limit_reg     <= limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    property p_fill_bound;
        @(posedge clk) disable iff (!rst_n)
        (SUM_W'(fill_reg[0]) + SUM_W'(fill_reg[1]) + SUM_W'(fill_reg[2]))
            <= SUM_W'(QUEUE_DEPTH);
    endproperty
    a_fill_bound: assert property (p_fill_bound)
        else $error("queued entries exceed the queue depth");

    a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg <= BUSY_W'(MAX_BUSY))
        else $error("busy count above its maximum");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DONE))
        else $error("accepted item did not enter the result cycle");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without an item in flight");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("slot pointer outside the table");
`endif

endmodule

`default_nettype wire

>>> design/wpq_ram.sv
// ----------------------------------------------------------------------------
// wpq_ram: generic single-clock ram
// One write port and one read port, read data registered with an enable.
// ----------------------------------------------------------------------------
`default_nettype none

module wpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
